>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files, clocked on clk_i and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/core/pap_pkg.sv
// Types, constants and helpers of the point attractor particle step.
`default_nettype none

package pap_pkg;

  // Register reset values
  localparam logic signed [31:0] CenterXReset = 32'sd26214400;
  localparam logic signed [31:0] CenterYReset = 32'sd19660800;
  localparam logic [30:0]        HorizonReset = 31'd6553600;
  localparam logic [23:0]        GravityReset = 24'd200000;

  // Softening of the squared distance, 0.001 in Q16.16
  localparam logic [6:0] SoftQ16 = 7'd66;

  // Result bits of the root and of each quotient, one per pipeline stage
  localparam int unsigned QBits = 32;

  typedef enum logic [1:0] {
    OUT_FREE      = 2'd0,
    OUT_CAPTURED  = 2'd1,
    OUT_DEFLECTED = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_HORIZON  = 2'd2,
    REG_GRAVITY  = 2'd3
  } reg_idx_e;

  // Particle data carried through the front stages and the root pipeline
  typedef struct packed {
    logic signed [31:0] npx;
    logic signed [31:0] npy;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [31:0]        adx;
    logic [31:0]        ady;
    logic               dxn;
    logic               dyn;
    logic [23:0]        body;
    logic [15:0]        dt;
  } part_t;

  // Data carried through the velocity divider pipeline
  typedef struct packed {
    logic signed [31:0] npx;
    logic signed [31:0] npy;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               dxn;
    logic               dyn;
    logic               cap;
    logic               defl;
  } fin_t;

  // Clamp to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -35'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/point_attractor_particle_step.sv
// Throughput: one particle per cycle while the skid stage is empty; the root and
// the pull and velocity dividers retire one bit per stage over 32 stages each,
// plus front, multiply and output stages.
// An output register with a skid stage parts the input from the output side.
// Reset (rst_ni low, asynchronous) empties the pipeline and restores registers.
`default_nettype none
`include "assert_macros.svh"

module point_attractor_particle_step import pap_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // config port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // particle in
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x, pos_y, vel_x, vel_y, body_radius, step_time
  input  logic [167:0] s_axis_tdata,
  // particle out
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_pos_x, new_pos_y, new_vel_x, new_vel_y, outcome, 6 zero bits
  output logic [135:0] m_axis_tdata
);

  // ---------------- configuration registers ----------------
  logic signed [31:0] center_x_q, center_y_q;
  logic [30:0]        horizon_q;
  logic [23:0]        gravity_q;
  logic               cfg_we;
  reg_idx_e           cfg_idx;

  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= CenterXReset;
      center_y_q <= CenterYReset;
      horizon_q  <= HorizonReset;
      gravity_q  <= GravityReset;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CENTER_X: center_x_q <= pwdata;
        REG_CENTER_Y: center_y_q <= pwdata;
        REG_HORIZON:  horizon_q  <= pwdata[30:0];
        REG_GRAVITY:  gravity_q  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CENTER_X: prdata = center_x_q;
      REG_CENTER_Y: prdata = center_y_q;
      REG_HORIZON:  prdata = {1'b0, horizon_q};
      REG_GRAVITY:  prdata = {8'd0, gravity_q};
      default:      prdata = '0;
    endcase
  end

  // ---------------- pipeline enable ----------------
  logic skid_v_q;
  logic en;
  assign en            = ~skid_v_q;
  assign s_axis_tready = en;

  // ---------------- stage 1: velocity times step ----------------
  logic signed [31:0] in_px, in_py, in_vx, in_vy;
  logic [23:0]        in_body;
  logic [15:0]        in_dt;
  logic signed [48:0] mx_d, my_d;

  assign in_px   = s_axis_tdata[31:0];
  assign in_py   = s_axis_tdata[63:32];
  assign in_vx   = s_axis_tdata[95:64];
  assign in_vy   = s_axis_tdata[127:96];
  assign in_body = s_axis_tdata[151:128];
  assign in_dt   = s_axis_tdata[167:152];
  assign mx_d    = in_vx * $signed({1'b0, in_dt});
  assign my_d    = in_vy * $signed({1'b0, in_dt});

  logic               v1_q;
  logic signed [31:0] px1_q, py1_q, vx1_q, vy1_q;
  logic signed [48:0] mx1_q, my1_q;
  logic [23:0]        body1_q;
  logic [15:0]        dt1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px1_q   <= in_px;
      py1_q   <= in_py;
      vx1_q   <= in_vx;
      vy1_q   <= in_vy;
      mx1_q   <= mx_d;
      my1_q   <= my_d;
      body1_q <= in_body;
      dt1_q   <= in_dt;
    end
  end

  // ---------------- stage 2: move and offset to center ----------------
  logic signed [33:0] sumx, sumy;
  logic signed [32:0] dx, dy;
  logic signed [32:0] adx_w, ady_w;
  part_t              p2_d;

  always_comb begin
    sumx     = {{2{px1_q[31]}}, px1_q} + {mx1_q[48], mx1_q[48:16]};
    sumy     = {{2{py1_q[31]}}, py1_q} + {my1_q[48], my1_q[48:16]};
    p2_d.npx = sat32({sumx[33], sumx});
    p2_d.npy = sat32({sumy[33], sumy});
    dx       = {center_x_q[31], center_x_q} - {p2_d.npx[31], p2_d.npx};
    dy       = {center_y_q[31], center_y_q} - {p2_d.npy[31], p2_d.npy};
    adx_w    = dx[32] ? -dx : dx;
    ady_w    = dy[32] ? -dy : dy;
    p2_d.adx = adx_w[31:0];
    p2_d.ady = ady_w[31:0];
    p2_d.dxn = dx[32];
    p2_d.dyn = dy[32];
    p2_d.vx  = vx1_q;
    p2_d.vy  = vy1_q;
    p2_d.body = body1_q;
    p2_d.dt  = dt1_q;
  end

  logic  v2_q;
  part_t p2_q;
  always_ff @(posedge clk_i) begin
    if (en) p2_q <= p2_d;
  end

  // ---------------- stage 3: squares ----------------
  logic        v3_q;
  logic [63:0] sqx3_q, sqy3_q;
  part_t       p3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx3_q <= p2_q.adx * p2_q.adx;
      sqy3_q <= p2_q.ady * p2_q.ady;
      p3_q   <= p2_q;
    end
  end

  // ---------------- stage 4: softened squared distance ----------------
  logic        v4_q;
  logic [49:0] dsq4_q;
  part_t       p4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      dsq4_q <= {2'b00, sqx3_q[63:16]} + {2'b00, sqy3_q[63:16]} + 50'(SoftQ16);
      p4_q   <= p3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // ---------------- root and pull divider, one bit per stage ----------------
  logic        r_v_in   [0:QBits-1];
  logic [63:0] r_rem_in [0:QBits-1];
  logic [31:0] r_root_in[0:QBits-1];
  logic [55:0] g_rem_in [0:QBits-1];
  logic [31:0] g_q_in   [0:QBits-1];
  logic        g_ov_in  [0:QBits-1];
  logic [49:0] r_dsq_in [0:QBits-1];
  part_t       r_p_in   [0:QBits-1];

  logic        r_v_q    [1:QBits];
  logic [63:0] r_rem_q  [1:QBits];
  logic [31:0] r_root_q [1:QBits];
  logic [55:0] g_rem_q  [1:QBits];
  logic [31:0] g_q_q    [1:QBits];
  logic        g_ov_q   [1:QBits];
  logic [49:0] r_dsq_q  [1:QBits];
  part_t       r_p_q    [1:QBits];

  for (genvar k = 0; k < QBits; k++) begin : g_root
    localparam int unsigned Bit = QBits - 1 - k;
    logic [64:0] trial;
    logic        r_take;
    logic [81:0] g_div;
    logic        g_take;

    if (k == 0) begin : g_head
      assign r_v_in[k]    = v4_q;
      assign r_rem_in[k]  = {dsq4_q, 14'd0};
      assign r_root_in[k] = '0;
      assign g_rem_in[k]  = {gravity_q, 32'd0};
      assign g_q_in[k]    = '0;
      assign g_ov_in[k]   = ({26'd0, gravity_q} >= dsq4_q);
      assign r_dsq_in[k]  = dsq4_q;
      assign r_p_in[k]    = p4_q;
    end else begin : g_link
      assign r_v_in[k]    = r_v_q[k];
      assign r_rem_in[k]  = r_rem_q[k];
      assign r_root_in[k] = r_root_q[k];
      assign g_rem_in[k]  = g_rem_q[k];
      assign g_q_in[k]    = g_q_q[k];
      assign g_ov_in[k]   = g_ov_q[k];
      assign r_dsq_in[k]  = r_dsq_q[k];
      assign r_p_in[k]    = r_p_q[k];
    end

    // try the next root bit: (r + b)^2 - r^2 = r*2b + b^2
    assign trial  = (65'(r_root_in[k]) << (Bit + 1)) + (65'd1 << (2 * Bit));
    assign r_take = {1'b0, r_rem_in[k]} >= trial;
    // restoring divide step for the pull
    assign g_div  = 82'(r_dsq_in[k]) << Bit;
    assign g_take = 82'(g_rem_in[k]) >= g_div;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        r_v_q[k+1] <= 1'b0;
      end else if (en) begin
        r_v_q[k+1] <= r_v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        r_rem_q[k+1]  <= r_take ? r_rem_in[k] - trial[63:0] : r_rem_in[k];
        r_root_q[k+1] <= r_take ? (r_root_in[k] | (32'd1 << Bit)) : r_root_in[k];
        g_rem_q[k+1]  <= g_take ? g_rem_in[k] - g_div[55:0] : g_rem_in[k];
        g_q_q[k+1]    <= g_take ? (g_q_in[k] | (32'd1 << Bit)) : g_q_in[k];
        g_ov_q[k+1]   <= g_ov_in[k];
        r_dsq_q[k+1]  <= r_dsq_in[k];
        r_p_q[k+1]    <= r_p_in[k];
      end
    end
  end

  // ---------------- stage E1: pull times step, zone tests ----------------
  logic [32:0] dist_w;
  logic [30:0] g_sat;
  logic [46:0] gt_prod;
  part_t       pe;

  assign pe      = r_p_q[QBits];
  assign dist_w  = {r_root_q[QBits], 1'b0};
  assign g_sat   = (g_ov_q[QBits] | g_q_q[QBits][31]) ? 31'h7FFFFFFF : g_q_q[QBits][30:0];
  assign gt_prod = g_sat * pe.dt;

  logic        e1_v_q;
  logic [30:0] e1_gt_q;
  logic [32:0] e1_dist_q;
  logic        e1_cap_q, e1_defl_q;
  part_t       e1_p_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_gt_q   <= gt_prod[46:16];
      e1_dist_q <= dist_w;
      e1_cap_q  <= dist_w <= (33'(horizon_q) + 33'(pe.body));
      e1_defl_q <= dist_w <= {horizon_q, 2'b00};
      e1_p_q    <= pe;
    end
  end

  // ---------------- stage E2: numerators of the velocity change ----------------
  logic        e2_v_q;
  logic [62:0] e2_nx_q, e2_ny_q;
  logic [32:0] e2_dist_q;
  fin_t        e2_f_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      e2_nx_q       <= e1_gt_q * e1_p_q.adx;
      e2_ny_q       <= e1_gt_q * e1_p_q.ady;
      e2_dist_q     <= e1_dist_q;
      e2_f_q.npx    <= e1_p_q.npx;
      e2_f_q.npy    <= e1_p_q.npy;
      e2_f_q.vx     <= e1_p_q.vx;
      e2_f_q.vy     <= e1_p_q.vy;
      e2_f_q.dxn    <= e1_p_q.dxn;
      e2_f_q.dyn    <= e1_p_q.dyn;
      e2_f_q.cap    <= e1_cap_q;
      e2_f_q.defl   <= e1_defl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_v_q <= 1'b0;
      e2_v_q <= 1'b0;
    end else if (en) begin
      e1_v_q <= r_v_q[QBits];
      e2_v_q <= e1_v_q;
    end
  end

  // ---------------- velocity dividers, one bit per stage ----------------
  logic        d_v_in   [0:QBits-1];
  logic [62:0] dx_rem_in[0:QBits-1];
  logic [62:0] dy_rem_in[0:QBits-1];
  logic [31:0] dx_q_in  [0:QBits-1];
  logic [31:0] dy_q_in  [0:QBits-1];
  logic        dx_ov_in [0:QBits-1];
  logic        dy_ov_in [0:QBits-1];
  logic [32:0] d_dist_in[0:QBits-1];
  fin_t        d_f_in   [0:QBits-1];

  logic        d_v_q    [1:QBits];
  logic [62:0] dx_rem_q [1:QBits];
  logic [62:0] dy_rem_q [1:QBits];
  logic [31:0] dx_q_q   [1:QBits];
  logic [31:0] dy_q_q   [1:QBits];
  logic        dx_ov_q  [1:QBits];
  logic        dy_ov_q  [1:QBits];
  logic [32:0] d_dist_q [1:QBits];
  fin_t        d_f_q    [1:QBits];

  for (genvar k = 0; k < QBits; k++) begin : g_vdiv
    localparam int unsigned Bit = QBits - 1 - k;
    logic [64:0] div_w;
    logic        x_take, y_take;

    if (k == 0) begin : g_head
      assign d_v_in[k]    = e2_v_q;
      assign dx_rem_in[k] = e2_nx_q;
      assign dy_rem_in[k] = e2_ny_q;
      assign dx_q_in[k]   = '0;
      assign dy_q_in[k]   = '0;
      assign dx_ov_in[k]  = {2'b00, e2_nx_q} >= {e2_dist_q, 32'd0};
      assign dy_ov_in[k]  = {2'b00, e2_ny_q} >= {e2_dist_q, 32'd0};
      assign d_dist_in[k] = e2_dist_q;
      assign d_f_in[k]    = e2_f_q;
    end else begin : g_link
      assign d_v_in[k]    = d_v_q[k];
      assign dx_rem_in[k] = dx_rem_q[k];
      assign dy_rem_in[k] = dy_rem_q[k];
      assign dx_q_in[k]   = dx_q_q[k];
      assign dy_q_in[k]   = dy_q_q[k];
      assign dx_ov_in[k]  = dx_ov_q[k];
      assign dy_ov_in[k]  = dy_ov_q[k];
      assign d_dist_in[k] = d_dist_q[k];
      assign d_f_in[k]    = d_f_q[k];
    end

    assign div_w  = 65'(d_dist_in[k]) << Bit;
    assign x_take = {2'b00, dx_rem_in[k]} >= div_w;
    assign y_take = {2'b00, dy_rem_in[k]} >= div_w;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_v_q[k+1] <= 1'b0;
      end else if (en) begin
        d_v_q[k+1] <= d_v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dx_rem_q[k+1] <= x_take ? dx_rem_in[k] - div_w[62:0] : dx_rem_in[k];
        dy_rem_q[k+1] <= y_take ? dy_rem_in[k] - div_w[62:0] : dy_rem_in[k];
        dx_q_q[k+1]   <= x_take ? (dx_q_in[k] | (32'd1 << Bit)) : dx_q_in[k];
        dy_q_q[k+1]   <= y_take ? (dy_q_in[k] | (32'd1 << Bit)) : dy_q_in[k];
        dx_ov_q[k+1]  <= dx_ov_in[k];
        dy_ov_q[k+1]  <= dy_ov_in[k];
        d_dist_q[k+1] <= d_dist_in[k];
        d_f_q[k+1]    <= d_f_in[k];
      end
    end
  end

  // ---------------- final velocity and outcome ----------------
  fin_t               ff;
  logic [32:0]        dvx, dvy;
  logic signed [34:0] vxe, vye, resx, resy;
  logic signed [31:0] nvx, nvy;
  outcome_e           outc;
  logic [135:0]       res_data;

  always_comb begin
    ff   = d_f_q[QBits];
    // a quotient of 2^32 or more saturates any velocity
    dvx  = dx_ov_q[QBits] ? 33'h1_0000_0000 : {1'b0, dx_q_q[QBits]};
    dvy  = dy_ov_q[QBits] ? 33'h1_0000_0000 : {1'b0, dy_q_q[QBits]};
    vxe  = {{3{ff.vx[31]}}, ff.vx};
    vye  = {{3{ff.vy[31]}}, ff.vy};
    resx = ff.dxn ? vxe - $signed({2'b00, dvx}) : vxe + $signed({2'b00, dvx});
    resy = ff.dyn ? vye - $signed({2'b00, dvy}) : vye + $signed({2'b00, dvy});
    if (ff.cap) begin
      nvx  = '0;
      nvy  = '0;
      outc = OUT_CAPTURED;
    end else if (ff.defl) begin
      nvx  = sat32(resx);
      nvy  = sat32(resy);
      outc = OUT_DEFLECTED;
    end else begin
      nvx  = ff.vx;
      nvy  = ff.vy;
      outc = OUT_FREE;
    end
    res_data = {6'd0, outc, nvy, nvx, ff.npy, ff.npx};
  end

  // ---------------- output register and skid ----------------
  logic         out_v_q;
  logic [135:0] out_data_q, skid_data_q;
  logic         incoming, taken;

  assign incoming = d_v_q[QBits] & en;
  assign taken    = out_v_q & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (taken) skid_v_q <= 1'b0;
    end else if (incoming) begin
      if (out_v_q && !m_axis_tready) skid_v_q <= 1'b1;
      else out_v_q <= 1'b1;
    end else if (taken) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (taken) out_data_q <= skid_data_q;
    end else if (incoming) begin
      if (out_v_q && !m_axis_tready) skid_data_q <= res_data;
      else out_data_q <= res_data;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------- assertions ----------------
  `ASSERT_IMP(a_skid_needs_out, skid_v_q, out_v_q, "skid holds a beat with the output empty")
  `ASSERT_NEXT(a_skid_holds, skid_v_q && !m_axis_tready, skid_v_q && $stable(skid_data_q), "skid beat lost while stalled")
  `ASSERT_IMP(a_capture_stops, m_axis_tvalid && (m_axis_tdata[129:128] == OUT_CAPTURED), m_axis_tdata[127:64] == 64'd0, "captured particle keeps velocity")

endmodule

`default_nettype wire

>>> tb/pap_checker.sv
// Checker: watches the particle streams and the APB port, predicts and compares results.
`default_nettype none

module pap_checker import pap_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [167:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [135:0] m_axis_tdata,
  output int           err_count,
  output int           pending
);

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [1:0]         kind;
  } step_res_t;

  logic signed [63:0] cen_x, cen_y;
  logic [63:0]        horizon, gravity;
  step_res_t          expected_q[$];

  assign pending = expected_q.size();

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Bitwise integer square root
  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic step_res_t advance(input logic [167:0] d);
    logic signed [63:0] px, py, vx, vy, dt, npx, npy, dx, dy, nvx, nvy;
    logic [63:0]        body, adx, ady, dsq, dist_v, g, gt, dvx, dvy;
    step_res_t          r;
    px = $signed(d[31:0]);
    py = $signed(d[63:32]);
    vx = $signed(d[95:64]);
    vy = $signed(d[127:96]);
    body = {40'd0, d[151:128]};
    dt = {48'd0, d[167:152]};
    // >>> on signed floors toward minus infinity
    npx = clamp32(px + ((vx * dt) >>> 16));
    npy = clamp32(py + ((vy * dt) >>> 16));
    dx = cen_x - npx;
    dy = cen_y - npy;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    dsq = ((adx * adx) >> 16) + ((ady * ady) >> 16) + 64'd66;
    dist_v = root64(dsq << 14) << 1;
    nvx = vx;
    nvy = vy;
    r.kind = OUT_FREE;
    if (dist_v <= horizon + body) begin
      nvx = 0;
      nvy = 0;
      r.kind = OUT_CAPTURED;
    end else if (dist_v <= 4 * horizon) begin
      g = (gravity << 32) / dsq;
      if (g > 64'h7FFFFFFF) g = 64'h7FFFFFFF;
      gt = (g * dt) >> 16;
      dvx = (gt * adx) / dist_v;
      dvy = (gt * ady) / dist_v;
      nvx = clamp32(dx < 0 ? vx - $signed(dvx) : vx + $signed(dvx));
      nvy = clamp32(dy < 0 ? vy - $signed(dvy) : vy + $signed(dvy));
      r.kind = OUT_DEFLECTED;
    end
    r.px = npx[31:0];
    r.py = npy[31:0];
    r.vx = nvx[31:0];
    r.vy = nvy[31:0];
    return r;
  endfunction

  // Register shadow, input predictions and output compare
  always @(posedge clk_i or negedge rst_ni) begin
    step_res_t e, a;
    if (!rst_ni) begin
      cen_x <= CenterXReset;
      cen_y <= CenterYReset;
      horizon <= HorizonReset;
      gravity <= GravityReset;
      err_count <= 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_CENTER_X: cen_x <= $signed(pwdata);
          REG_CENTER_Y: cen_y <= $signed(pwdata);
          REG_HORIZON:  horizon <= {33'd0, pwdata[30:0]};
          REG_GRAVITY:  gravity <= {40'd0, pwdata[23:0]};
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(advance(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        a.px = m_axis_tdata[31:0];
        a.py = m_axis_tdata[63:32];
        a.vx = m_axis_tdata[95:64];
        a.vy = m_axis_tdata[127:96];
        a.kind = m_axis_tdata[129:128];
        if (expected_q.size() == 0) begin
          if (err_count < 10) $display("unexpected output beat %h", m_axis_tdata);
          err_count <= err_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e !== a || m_axis_tdata[135:130] !== 6'd0) begin
            if (err_count < 10)
              $display("mismatch exp px %h py %h vx %h vy %h k %0d / got px %h py %h vx %h vy %h k %0d",
                       e.px, e.py, e.vx, e.vy, e.kind, a.px, a.py, a.vx, a.vy, a.kind);
            err_count <= err_count + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Top of the testbench: clock, reset, stimulus, output stalls and verdict.
`default_nettype none

module tb_top import pap_pkg::*;;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // pos_x, pos_y, vel_x, vel_y, body_radius, step_time
  logic [167:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // new_pos_x, new_pos_y, new_vel_x, new_vel_y, outcome, 6 zero bits
  logic [135:0] m_axis_tdata;
  int           err_count, pending;
  int           cycles = 0;
  logic         hold_long = 1'b0;

  localparam int Latency = 71;
  localparam int CycleLimit = 400000;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  point_attractor_particle_step u_dut (.*);

  pap_checker u_chk (.*);

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic int short_gap();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) :
           (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
  endfunction

  // Receiver stalls, with one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_long) begin
      m_axis_tready <= 1'b0;
    end else if (cycles % 2000 < 400) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= (short_gap() == 0);
    end
  end

  task automatic reg_write(input reg_idx_e idx, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Valid stays high after a beat unless a gap follows
  task automatic send_particle(input logic [31:0] px, py, vx, vy,
                               input logic [23:0] body, input logic [15:0] dt,
                               input bit gaps);
    int g;
    g = gaps ? short_gap() : 0;
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tdata <= {dt, body, vy, vx, py, px};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  // Random particle: mostly around the center so capture and deflection occur
  task automatic random_particle(input logic [31:0] cx, cy, input int spread);
    logic [31:0] px, py, vx, vy;
    if ($urandom_range(0, 9) == 0) begin
      px = $urandom;
      py = $urandom;
      vx = $urandom;
      vy = $urandom;
    end else begin
      px = cx + $signed($urandom_range(0, 2 * spread)) - spread;
      py = cy + $signed($urandom_range(0, 2 * spread)) - spread;
      vx = $signed($urandom_range(0, 2 ** 24)) - 2 ** 23;
      vy = $signed($urandom_range(0, 2 ** 24)) - 2 ** 23;
    end
    send_particle(px, py, vx, vy, 24'($urandom_range(0, 24'hFFFFFF) & ($urandom_range(0, 1) ?
                  24'hFFFFFF : 24'h0FFFFF)), 16'($urandom_range(0, 16'hFFFF)), 1'b1);
  endtask

  initial begin
    logic [31:0] cx, cy;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, overflow, zero radii, each outcome
    send_particle(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'hFFFFFF,
                  16'hFFFF, 1'b0);
    send_particle(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 24'h0, 16'hFFFF,
                  1'b0);
    send_particle(32'h0, 32'h0, 32'h0, 32'h0, 24'h0, 16'h0, 1'b0);
    send_particle(CenterXReset, CenterYReset, 32'h0, 32'h0, 24'h0, 16'h1000, 1'b0);
    send_particle(CenterXReset + 32'h00640000, CenterYReset, 32'h0, 32'h0, 24'h0,
                  16'h1000, 1'b0);
    send_particle(CenterXReset + 32'h00C80000, CenterYReset - 32'h00500000, 32'h00010000,
                  32'hFFFF0000, 24'h10000, 16'hFFFF, 1'b0);
    send_particle(CenterXReset - 32'h01900000, CenterYReset, 32'h0, 32'h0, 24'h0,
                  16'hFFFF, 1'b0);
    send_particle(CenterXReset - 32'h01900001, CenterYReset, 32'h0, 32'h0, 24'h0,
                  16'hFFFF, 1'b0);
    send_particle(32'hAAAAAAAA, 32'h55555555, 32'h55555555, 32'hAAAAAAAA, 24'hAAAAAA,
                  16'h5555, 1'b0);
    drain();

    // Zero radii and strongest pull at extreme center
    reg_write(REG_HORIZON, 32'h0);
    reg_write(REG_GRAVITY, 32'hFFFFFF);
    reg_write(REG_CENTER_X, 32'h80000000);
    reg_write(REG_CENTER_Y, 32'h7FFFFFFF);
    send_particle(32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0, 24'h0, 16'hFFFF, 1'b0);
    send_particle(32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0, 24'h1, 16'hFFFF, 1'b0);
    drain();
    reg_write(REG_HORIZON, 32'h7FFFFFFF);
    send_particle(32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0, 24'h0, 16'hFFFF, 1'b0);
    send_particle(32'h0, 32'h0, 32'h7FFFFFFF, 32'h80000000, 24'hFFFFFF, 16'hFFFF, 1'b0);
    drain();

    // Random phases through several settings
    for (int ph = 0; ph < 6; ph++) begin
      cx = $urandom;
      cy = $urandom;
      reg_write(REG_CENTER_X, cx);
      reg_write(REG_CENTER_Y, cy);
      reg_write(REG_HORIZON, (ph == 5) ? 32'h7FFFFFFF : $urandom_range(0, 32'h0200_0000));
      reg_write(REG_GRAVITY, (ph == 0) ? 32'h0 : $urandom_range(0, 24'hFFFFFF));
      if (ph == 2) begin
        // Long receiver hold-off while the sender keeps offering
        fork
          begin
            hold_long <= 1'b1;
            repeat (300) @(posedge clk_i);
            hold_long <= 1'b0;
          end
          repeat (100) random_particle(cx, cy, 32'h0800_0000);
        join
      end else begin
        repeat (100) random_particle(cx, cy, 32'h0800_0000);
      end
      drain();
    end

    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
